@@ rtl/fmp_pkg.sv @@
// Shared constants, types and key table for the FLAC metadata parser.
`default_nettype none
package fmp_pkg;
    localparam int WINDOW_BYTES      = 2048;
    localparam int MAX_TAG_CHARS     = 64;
    localparam int MAX_COMMENT_BLOCK = 512;
    localparam int POS_W             = $clog2(WINDOW_BYTES) + 1;
    localparam int SAMP_W            = 36;
    localparam int RATE_W            = 20;
    localparam int OUT_DW            = 136;

    localparam logic [1:0] KIND_TAG = 2'd0;
    localparam logic [1:0] KIND_SUM = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [1:0] ERR_MAGIC  = 2'd0;
    localparam logic [1:0] ERR_WINDOW = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    localparam logic [2:0] TAG_TRACK = 3'd4;
    localparam logic [2:0] TAG_NONE  = 3'd7;

    typedef struct packed {
        logic step;
        logic sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] nres;
        logic       need_div;
    } t_stat;

    // keys padded with spaces to 12 characters, first character at the top
    localparam logic [95:0] KEY_TEXT [5] = '{
        "TRACKNUMBER=", "ARTIST=     ", "ALBUM=      ", "TITLE=      ", "DATE=       "};
    localparam logic [3:0] KEY_LEN [5] = '{4'd12, 4'd7, 4'd6, 4'd6, 4'd5};
    localparam logic [2:0] KEY_TAG [5] = '{TAG_TRACK, 3'd0, 3'd1, 3'd2, 3'd3};

    function automatic logic [7:0] key_char(input int k, input logic [3:0] i);
        logic [95:0] t;
        t = KEY_TEXT[k];
        return t[8*(11 - int'(i)) +: 8];
    endfunction

    function automatic logic [7:0] magic_char(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0: c = 8'h66;
            2'd1: c = 8'h4C;
            2'd2: c = 8'h61;
            default: c = 8'h43;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

@@ rtl/flac_metadata_parser.sv @@
// Top level of the FLAC metadata parser.
//  channel   dir  tdata                   tuser        tlast
//  s_axis    in   data_byte[7:0]          file_start   -
//  m_axis    out  tag, value, summary     kind[1:0]    value_last
// One item per cycle is taken when it causes no result. Each result item is held in
// the output register until taken, and input stalls meanwhile. A summary runs the
// divider for the duration figure, and input also stalls while it works.
// Reset is synchronous; no clearing pass is needed.
`default_nettype none
module flac_metadata_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [7:0]    i_s_axis_tdata,   // data_byte[7:0]
    input  wire logic          i_s_axis_tuser,   // file_start
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // tag_id[1:0] value_byte[9:2] sample_rate[29:10] total_samples[65:30]
    // duration_seconds[97:66] track_number[129:98] error_code[131:130]
    output logic [fmp_pkg::OUT_DW-1:0] o_m_axis_tdata,
    output logic [1:0]         o_m_axis_tuser,   // kind[1:0]
    output logic               o_m_axis_tlast    // value_last
);
    fmp_pkg::t_cmd  cmd;
    fmp_pkg::t_stat stat;
    logic div_start, div_done;
    logic [fmp_pkg::SAMP_W-1:0] quotient, samples;
    logic [fmp_pkg::RATE_W-1:0] rate;

    fmp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_s_axis_tvalid),
        .i_out_ready(i_m_axis_tready), .i_stat(stat), .i_div_done(div_done),
        .o_in_ready(o_s_axis_tready), .o_out_valid(o_m_axis_tvalid),
        .o_div_start(div_start), .o_cmd(cmd)
    );

    fmp_dpath u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_byte(i_s_axis_tdata),
        .i_start(i_s_axis_tuser), .i_quotient(quotient), .o_stat(stat),
        .o_samples(samples), .o_rate(rate), .o_tdata(o_m_axis_tdata),
        .o_tuser(o_m_axis_tuser), .o_tlast(o_m_axis_tlast)
    );

    fmp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_dividend(samples),
        .i_divisor(rate), .o_done(div_done), .o_quotient(quotient)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input taken while a result is pending");
    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != fmp_pkg::KIND_TAG) |-> !o_m_axis_tlast)
        else $error("value_last on a non-tag item");
    a_dur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == fmp_pkg::KIND_SUM) |->
        ({4'd0, o_m_axis_tdata[97:66]} <= o_m_axis_tdata[65:30]))
        else $error("duration exceeds sample count");
endmodule
`default_nettype wire

@@ rtl/fmp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the duration figure.
`default_nettype none
module fmp_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [fmp_pkg::SAMP_W-1:0] i_dividend,
    input  wire logic [fmp_pkg::RATE_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [fmp_pkg::SAMP_W-1:0]     o_quotient
);
    localparam int CNT_W = $clog2(fmp_pkg::SAMP_W);

    logic [fmp_pkg::RATE_W-1:0] r_rem;
    logic [fmp_pkg::SAMP_W-1:0] r_quo;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy, r_done;
    logic [fmp_pkg::RATE_W:0]   trial;
    logic                       qbit;
    logic [fmp_pkg::RATE_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[fmp_pkg::SAMP_W-1]};
        qbit  = (trial >= {1'b0, i_divisor});
        n_rem = qbit ? fmp_pkg::RATE_W'(trial - {1'b0, i_divisor})
                     : trial[fmp_pkg::RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[fmp_pkg::SAMP_W-2:0], qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(fmp_pkg::SAMP_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

@@ rtl/fmp_dpath.sv @@
// Parser datapath: phase, counters, stream info and comment fields, result slots.
`default_nettype none
module fmp_dpath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fmp_pkg::t_cmd               i_cmd,
    input  wire logic [7:0]                  i_byte,
    input  wire logic                        i_start,
    input  wire logic [fmp_pkg::SAMP_W-1:0]  i_quotient,
    output fmp_pkg::t_stat                   o_stat,
    output logic [fmp_pkg::SAMP_W-1:0]       o_samples,
    output logic [fmp_pkg::RATE_W-1:0]       o_rate,
    output logic [fmp_pkg::OUT_DW-1:0]       o_tdata,
    output logic [1:0]                       o_tuser,
    output logic                             o_tlast
);
    typedef enum logic [3:0] {
        PH_MAGIC, PH_HEADER, PH_SINFO, PH_SKIP, PH_VLEN, PH_VEND,
        PH_COUNT, PH_ELEN, PH_EDATA, PH_DONE, PH_ERR
    } t_phase;

    localparam logic [25:0] WIN = 26'(fmp_pkg::WINDOW_BYTES);

    t_phase r_phase, n_phase;
    logic [fmp_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [23:0] r_fc, n_fc, r_blen, n_blen;
    logic        r_last, n_last;
    logic [31:0] r_ash, n_ash, r_cleft, n_cleft, r_eleft, n_eleft;
    logic [4:0]  r_cand, n_cand;
    logic [2:0]  r_ctag, n_ctag;
    logic [7:0]  r_chars, n_chars;
    logic [fmp_pkg::RATE_W-1:0] r_rate, n_rate;
    logic [fmp_pkg::SAMP_W-1:0] r_samp, n_samp;
    logic [31:0] r_track, n_track;

    // result slots
    logic [1:0] r_s0_kind, r_s0_tag, r_s0_ec, r_s1_kind, r_s1_ec;
    logic [7:0] r_s0_vb;
    logic       r_s0_vl;

    logic       fin, er, tg, tvl;
    logic [1:0] ec;
    logic [7:0] tvb;
    logic [1:0] ttag;

    always_comb begin
        logic [25:0] p1;
        logic [23:0] idx;
        logic [7:0]  f;
        logic        hit;
        logic [23:0] len;
        logic [6:0]  btype;
        n_phase = r_phase;  n_pos = r_pos;     n_fc = r_fc;       n_blen = r_blen;
        n_last = r_last;    n_ash = r_ash;     n_cleft = r_cleft; n_eleft = r_eleft;
        n_cand = r_cand;    n_ctag = r_ctag;   n_chars = r_chars; n_rate = r_rate;
        n_samp = r_samp;    n_track = r_track;
        if (i_start) begin
            n_phase = PH_MAGIC; n_pos = '0; n_fc = '0; n_blen = '0; n_last = 1'b0;
            n_ash = '0; n_cleft = '0; n_eleft = '0; n_cand = 5'h1F;
            n_ctag = fmp_pkg::TAG_NONE; n_chars = '0; n_rate = '0; n_samp = '0;
            n_track = '0;
        end
        fin = 1'b0; er = 1'b0; ec = fmp_pkg::ERR_MAGIC; tg = 1'b0; tvl = 1'b0;
        tvb = '0; ttag = '0; hit = 1'b0; f = '0;
        p1  = 26'(n_pos) + 26'd1;
        idx = n_fc;
        len = n_blen;
        btype = n_ash[6:0];
        case (n_phase)
            PH_MAGIC: begin
                if (i_byte != fmp_pkg::magic_char(idx[1:0])) begin
                    er = 1'b1; ec = fmp_pkg::ERR_MAGIC;
                end else begin
                    n_fc = n_fc + 1'b1;
                    if (n_fc >= 24'd4) begin
                        if (p1 + 26'd4 >= WIN) begin er = 1'b1; ec = fmp_pkg::ERR_WINDOW; end
                        else begin n_phase = PH_HEADER; n_fc = '0; end
                    end
                end
            end
            PH_HEADER: begin
                if (idx == 24'd0) begin
                    n_last = i_byte[7]; n_ash = {25'd0, i_byte[6:0]}; n_blen = '0;
                end else begin
                    n_blen = {n_blen[15:0], i_byte};
                end
                n_fc = n_fc + 1'b1;
                len = n_blen;
                btype = n_ash[6:0];
                if (n_fc >= 24'd4) begin
                    if (btype == 7'd0 && len == 24'd34) begin
                        if (p1 + 26'd34 >= WIN) begin er = 1'b1; ec = fmp_pkg::ERR_WINDOW; end
                        else begin n_phase = PH_SINFO; n_fc = '0; end
                    end else if (btype == 7'd4 && len < 24'(fmp_pkg::MAX_COMMENT_BLOCK)) begin
                        if (p1 + 26'(len) >= WIN) begin er = 1'b1; ec = fmp_pkg::ERR_WINDOW; end
                        else if (n_blen < 24'd4) begin er = 1'b1; ec = fmp_pkg::ERR_OVERRUN; end
                        else begin n_phase = PH_VLEN; n_fc = '0; n_ash = '0; end
                    end else if (n_last) begin
                        fin = 1'b1;
                    end else if (p1 + 26'(len) + 26'd4 >= WIN) begin
                        er = 1'b1; ec = fmp_pkg::ERR_WINDOW;
                    end else if (len == 24'd0) begin
                        n_phase = PH_HEADER; n_fc = '0;
                    end else begin
                        n_phase = PH_SKIP; n_fc = len;
                    end
                end
            end
            PH_SINFO: begin
                if (idx == 24'd10) n_rate = {i_byte, 12'd0};
                else if (idx == 24'd11) n_rate = n_rate | {8'd0, i_byte, 4'd0};
                else if (idx == 24'd12) n_rate = n_rate | {16'd0, i_byte[7:4]};
                else if (idx == 24'd13) n_samp = {i_byte[3:0], 32'd0};
                else if (idx >= 24'd14 && idx <= 24'd17)
                    n_samp = n_samp | (36'(i_byte) << (8 * (17 - int'(idx[4:0]))));
                n_fc = n_fc + 1'b1;
                if (n_fc >= 24'd34) begin
                    if (n_last) fin = 1'b1;
                    else if (p1 + 26'd4 >= WIN) begin er = 1'b1; ec = fmp_pkg::ERR_WINDOW; end
                    else begin n_phase = PH_HEADER; n_fc = '0; end
                end
            end
            PH_SKIP: begin
                if (n_fc != '0) n_fc = n_fc - 1'b1;
                if (n_fc == '0) begin
                    if (p1 + 26'd4 >= WIN) begin er = 1'b1; ec = fmp_pkg::ERR_WINDOW; end
                    else begin n_phase = PH_HEADER; n_fc = '0; end
                end
            end
            PH_VLEN, PH_COUNT, PH_ELEN: begin
                if (n_blen != '0) n_blen = n_blen - 1'b1;
                n_ash = n_ash | (32'(i_byte) << (8 * int'(idx[1:0])));
                n_fc = n_fc + 1'b1;
                if (n_fc >= 24'd4) begin
                    if (n_phase == PH_VLEN) begin
                        if (n_ash > 32'(n_blen)) begin er = 1'b1; ec = fmp_pkg::ERR_OVERRUN; end
                        else if (n_ash == '0) begin
                            if (n_blen < 24'd4) begin er = 1'b1; ec = fmp_pkg::ERR_OVERRUN; end
                            else begin n_phase = PH_COUNT; n_fc = '0; n_ash = '0; end
                        end else begin
                            n_phase = PH_VEND; n_fc = n_ash[23:0];
                        end
                    end else if (n_phase == PH_COUNT) begin
                        n_cleft = n_ash;
                        if (n_cleft == '0) fin = 1'b1;
                        else if (n_blen < 24'd4) begin er = 1'b1; ec = fmp_pkg::ERR_OVERRUN; end
                        else begin n_phase = PH_ELEN; n_fc = '0; n_ash = '0; end
                    end else begin
                        if (n_ash > 32'(n_blen)) begin
                            er = 1'b1; ec = fmp_pkg::ERR_OVERRUN;
                        end else begin
                            n_eleft = n_ash; n_cand = 5'h1F; n_ctag = fmp_pkg::TAG_NONE;
                            n_chars = '0; n_fc = '0;
                            if (n_eleft == '0) begin
                                n_cleft = n_cleft - 1'b1;
                                if (n_cleft == '0) fin = 1'b1;
                                else if (n_blen < 24'd4) begin
                                    er = 1'b1; ec = fmp_pkg::ERR_OVERRUN;
                                end else begin n_phase = PH_ELEN; n_fc = '0; n_ash = '0; end
                            end else begin
                                n_phase = PH_EDATA;
                            end
                        end
                    end
                end
            end
            PH_VEND: begin
                if (n_blen != '0) n_blen = n_blen - 1'b1;
                if (n_fc != '0) n_fc = n_fc - 1'b1;
                if (n_fc == '0) begin
                    if (n_blen < 24'd4) begin er = 1'b1; ec = fmp_pkg::ERR_OVERRUN; end
                    else begin n_phase = PH_COUNT; n_fc = '0; n_ash = '0; end
                end
            end
            PH_EDATA: begin
                if (n_blen != '0) n_blen = n_blen - 1'b1;
                if (n_ctag == fmp_pkg::TAG_NONE && n_cand != '0) begin
                    f = (i_byte >= 8'h61 && i_byte <= 8'h7A) ? i_byte - 8'd32 : i_byte;
                    for (int k = 0; k < 5; k++) begin
                        if (n_cand[k]) begin
                            if (idx >= 24'(fmp_pkg::KEY_LEN[k]) ||
                                f != fmp_pkg::key_char(k, idx[3:0])) begin
                                n_cand[k] = 1'b0;
                            end else if (idx == 24'(fmp_pkg::KEY_LEN[k]) - 24'd1) begin
                                n_ctag = fmp_pkg::KEY_TAG[k];
                                hit = 1'b1;
                            end
                        end
                    end
                    if (hit) begin
                        n_cand = '0;
                        if (n_ctag == fmp_pkg::TAG_TRACK) n_track = '0;
                    end
                end else if (n_ctag < fmp_pkg::TAG_TRACK) begin
                    if (n_chars < 8'(fmp_pkg::MAX_TAG_CHARS)) begin
                        tg = 1'b1; tvb = i_byte; ttag = n_ctag[1:0];
                        tvl = (n_eleft == 32'd1) ||
                              (9'(n_chars) + 9'd1 == 9'(fmp_pkg::MAX_TAG_CHARS));
                        n_chars = n_chars + 1'b1;
                    end
                end else if (n_ctag == fmp_pkg::TAG_TRACK) begin
                    if (i_byte >= 8'h30 && i_byte <= 8'h39)
                        n_track = (n_track << 3) + (n_track << 1) + 32'(i_byte - 8'h30);
                    else
                        n_ctag = fmp_pkg::TAG_NONE;
                end
                n_fc = n_fc + 1'b1;
                n_eleft = n_eleft - 1'b1;
                if (n_eleft == '0) begin
                    n_cleft = n_cleft - 1'b1;
                    if (n_cleft == '0) fin = 1'b1;
                    else if (n_blen < 24'd4) begin er = 1'b1; ec = fmp_pkg::ERR_OVERRUN; end
                    else begin n_phase = PH_ELEN; n_fc = '0; n_ash = '0; end
                end
            end
            default: ;
        endcase
        if (er) n_phase = PH_ERR;
        else if (fin) n_phase = PH_DONE;
        if (n_pos != '1) n_pos = n_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_pos <= '0; r_fc <= '0; r_blen <= '0; r_last <= 1'b0;
            r_ash <= '0; r_cleft <= '0; r_eleft <= '0; r_cand <= 5'h1F;
            r_ctag <= fmp_pkg::TAG_NONE; r_chars <= '0; r_rate <= '0; r_samp <= '0;
            r_track <= '0;
        end else if (i_cmd.step) begin
            r_phase <= n_phase; r_pos <= n_pos; r_fc <= n_fc; r_blen <= n_blen;
            r_last <= n_last; r_ash <= n_ash; r_cleft <= n_cleft; r_eleft <= n_eleft;
            r_cand <= n_cand; r_ctag <= n_ctag; r_chars <= n_chars; r_rate <= n_rate;
            r_samp <= n_samp; r_track <= n_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_s0_tag <= ttag;
            r_s0_vb  <= tvb;
            r_s0_vl  <= tvl;
            r_s0_ec  <= ec;
            r_s1_ec  <= ec;
            r_s1_kind <= fin ? fmp_pkg::KIND_SUM : fmp_pkg::KIND_ERR;
            if (tg) r_s0_kind <= fmp_pkg::KIND_TAG;
            else    r_s0_kind <= fin ? fmp_pkg::KIND_SUM : fmp_pkg::KIND_ERR;
        end
    end

    assign o_stat.nres     = {1'b0, tg} + {1'b0, fin | er};
    assign o_stat.need_div = fin;
    assign o_samples       = r_samp;
    assign o_rate          = r_rate;

    always_comb begin
        logic [1:0]  kind, ecode;
        logic [31:0] dur;
        kind  = i_cmd.sel ? r_s1_kind : r_s0_kind;
        ecode = i_cmd.sel ? r_s1_ec : r_s0_ec;
        dur   = (r_rate == '0) ? 32'd0 : i_quotient[31:0];
        o_tdata = '0;
        o_tlast = 1'b0;
        o_tuser = kind;
        case (kind)
            fmp_pkg::KIND_TAG: begin
                o_tdata[1:0] = r_s0_tag;
                o_tdata[9:2] = r_s0_vb;
                o_tlast      = r_s0_vl;
            end
            fmp_pkg::KIND_SUM: begin
                o_tdata[29:10]  = r_rate;
                o_tdata[65:30]  = r_samp;
                o_tdata[97:66]  = dur;
                o_tdata[129:98] = r_track;
            end
            default: o_tdata[131:130] = ecode;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/fmp_ctrl.sv @@
// Handshake and result sequencing controller.
`default_nettype none
module fmp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_ready,
    input  wire fmp_pkg::t_stat i_stat,
    input  wire logic           i_div_done,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic                o_div_start,
    output fmp_pkg::t_cmd       o_cmd
);
    typedef enum logic [2:0] {S_IN, S_DSTART, S_DWAIT, S_OUT0, S_OUT1} t_state;

    t_state     r_state;
    logic [1:0] r_nres;
    logic       r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_nres  <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IN: begin
                    if (i_in_valid) begin
                        r_nres <= i_stat.nres;
                        if (i_stat.need_div) begin
                            r_state <= S_DSTART;
                            r_start <= 1'b1;
                        end else if (i_stat.nres != 2'd0) begin
                            r_state <= S_OUT0;
                        end
                    end
                end
                S_DSTART: r_state <= S_DWAIT;
                S_DWAIT: if (i_div_done) r_state <= S_OUT0;
                S_OUT0: begin
                    if (i_out_ready) r_state <= (r_nres == 2'd2) ? S_OUT1 : S_IN;
                end
                S_OUT1: if (i_out_ready) r_state <= S_IN;
                default: r_state <= S_IN;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IN);
    assign o_out_valid = (r_state == S_OUT0) || (r_state == S_OUT1);
    assign o_div_start = r_start;
    assign o_cmd.step  = (r_state == S_IN) && i_in_valid;
    assign o_cmd.sel   = (r_state == S_OUT1);
endmodule
`default_nettype wire

@@ test/flac_metadata_parser_tb.sv @@
// Self-checking testbench for the FLAC metadata parser: streamed files against a predictor.
`default_nettype none
module flac_metadata_parser_tb;
    typedef enum int {
        P_MAGIC, P_HEADER, P_SINFO, P_SKIP, P_VLEN, P_VEND,
        P_COUNT, P_ELEN, P_EDATA, P_DONE, P_ERR
    } t_parse_phase;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  tag;
        logic [7:0]  vbyte;
        logic        vlast;
        logic [19:0] rate;
        logic [35:0] samples;
        logic [31:0] dur;
        logic [31:0] track;
        logic [1:0]  err;
    } t_meta_result;

    class flac_scoreboard;
        t_meta_result pending_q[$];
        int           mismatches;
        t_parse_phase ph;
        int unsigned  fpos, fcnt, blen, is_last, shift, comments, eleft;
        int unsigned  cands, cur_tag, nchars, rate, track;
        longint unsigned samples;
        string        keys[5] = '{"TRACKNUMBER=", "ARTIST=", "ALBUM=", "TITLE=", "DATE="};
        int unsigned  key_tags[5] = '{fmp_pkg::TAG_TRACK, 0, 1, 2, 3};

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            ph = P_MAGIC; fpos = 0; fcnt = 0; blen = 0; is_last = 0; shift = 0;
            comments = 0; eleft = 0; cands = 5'h1F; cur_tag = fmp_pkg::TAG_NONE; nchars = 0;
            rate = 0; samples = 0; track = 0;
        endfunction

        function void push(logic [1:0] k, logic [1:0] t, logic [7:0] v, logic l,
                           logic [19:0] r, logic [35:0] s, logic [31:0] d,
                           logic [31:0] tr, logic [1:0] e);
            t_meta_result x;
            x.kind = k; x.tag = t; x.vbyte = v; x.vlast = l; x.rate = r;
            x.samples = s; x.dur = d; x.track = tr; x.err = e;
            pending_q.push_back(x);
        endfunction

        function void summarise();
            longint unsigned d;
            d = (rate != 0) ? samples / rate : 0;
            push(fmp_pkg::KIND_SUM, 0, 0, 0, rate, samples[35:0], d[31:0], track, 0);
            ph = P_DONE;
        endfunction

        function void abort(logic [1:0] code);
            push(fmp_pkg::KIND_ERR, 0, 0, 0, 0, 0, 0, 0, code);
            ph = P_ERR;
        endfunction

        function void to_header(int unsigned p);
            if (p + 4 >= fmp_pkg::WINDOW_BYTES) abort(fmp_pkg::ERR_WINDOW);
            else begin
                ph = P_HEADER; fcnt = 0;
            end
        endfunction

        function void to_field(t_parse_phase nxt);
            if (blen < 4) abort(fmp_pkg::ERR_OVERRUN);
            else begin
                ph = nxt; fcnt = 0; shift = 0;
            end
        endfunction

        function void entry_done();
            comments--;
            if (comments == 0) summarise();
            else to_field(P_ELEN);
        endfunction

        function void header_complete(int unsigned p);
            int unsigned typ;
            typ = shift & 32'h7F;
            if (typ == 0 && blen == 34) begin
                if (p + 34 >= fmp_pkg::WINDOW_BYTES) abort(fmp_pkg::ERR_WINDOW);
                else begin
                    ph = P_SINFO; fcnt = 0;
                end
            end else if (typ == 4 && blen < fmp_pkg::MAX_COMMENT_BLOCK) begin
                if (p + blen >= fmp_pkg::WINDOW_BYTES) abort(fmp_pkg::ERR_WINDOW);
                else to_field(P_VLEN);
            end else if (is_last) summarise();
            else if (p + blen + 4 >= fmp_pkg::WINDOW_BYTES) abort(fmp_pkg::ERR_WINDOW);
            else if (blen == 0) to_header(p);
            else begin
                ph = P_SKIP; fcnt = blen;
            end
        endfunction

        function void value_byte(int unsigned b);
            int unsigned f, idx;
            bit l;
            idx = fcnt;
            if (cur_tag == fmp_pkg::TAG_NONE && cands != 0) begin
                f = (b >= "a" && b <= "z") ? b - 32 : b;
                for (int k = 0; k < 5; k++) begin
                    if (!cands[k]) continue;
                    if (idx >= keys[k].len() || f != keys[k][idx]) cands[k] = 1'b0;
                    else if (idx == keys[k].len() - 1) begin
                        cur_tag = key_tags[k];
                        cands = 0;
                        if (cur_tag == fmp_pkg::TAG_TRACK) track = 0;
                    end
                end
            end else if (cur_tag < fmp_pkg::TAG_TRACK) begin
                if (nchars < fmp_pkg::MAX_TAG_CHARS) begin
                    l = (eleft == 1 || nchars + 1 == fmp_pkg::MAX_TAG_CHARS);
                    push(fmp_pkg::KIND_TAG, cur_tag[1:0], b[7:0], l, 0, 0, 0, 0, 0);
                    nchars++;
                end
            end else if (cur_tag == fmp_pkg::TAG_TRACK) begin
                if (b >= "0" && b <= "9") track = track * 10 + (b - "0");
                else cur_tag = fmp_pkg::TAG_NONE;
            end
            fcnt++;
            eleft--;
            if (eleft == 0) entry_done();
        endfunction

        // advance the predicted parser by one accepted input item
        function void note_byte(logic [7:0] data, logic fs);
            int unsigned b, pos, idx;
            b = data;
            if (fs) clear();
            pos = fpos;
            idx = fcnt;
            case (ph)
                P_MAGIC: begin
                    if (b != (("fLaC" >> (8 * (3 - (idx & 3)))) & 8'hFF))
                        abort(fmp_pkg::ERR_MAGIC);
                    else begin
                        fcnt++;
                        if (fcnt >= 4) to_header(pos + 1);
                    end
                end
                P_HEADER: begin
                    if (idx == 0) begin
                        is_last = b >> 7; shift = b & 32'h7F; blen = 0;
                    end else blen = ((blen << 8) | b) & 32'hFFFFFF;
                    fcnt++;
                    if (fcnt >= 4) header_complete(pos + 1);
                end
                P_SINFO: begin
                    if (idx == 10) rate = b << 12;
                    else if (idx == 11) rate |= b << 4;
                    else if (idx == 12) rate = (rate | (b >> 4)) & 32'hFFFFF;
                    else if (idx == 13) samples = longint'(b & 15) << 32;
                    else if (idx >= 14 && idx <= 17)
                        samples |= longint'(b) << (8 * (17 - idx));
                    fcnt++;
                    if (fcnt >= 34) begin
                        if (is_last) summarise();
                        else to_header(pos + 1);
                    end
                end
                P_SKIP: begin
                    if (fcnt > 0) fcnt--;
                    if (fcnt == 0) to_header(pos + 1);
                end
                P_VLEN, P_COUNT, P_ELEN: begin
                    if (blen > 0) blen--;
                    shift |= b << (8 * (idx & 3));
                    fcnt++;
                    if (fcnt >= 4) begin
                        if (ph == P_VLEN) begin
                            if (shift > blen) abort(fmp_pkg::ERR_OVERRUN);
                            else if (shift == 0) to_field(P_COUNT);
                            else begin
                                ph = P_VEND; fcnt = shift;
                            end
                        end else if (ph == P_COUNT) begin
                            comments = shift;
                            if (comments == 0) summarise();
                            else to_field(P_ELEN);
                        end else if (shift > blen) abort(fmp_pkg::ERR_OVERRUN);
                        else begin
                            eleft = shift; cands = 5'h1F; cur_tag = fmp_pkg::TAG_NONE;
                            nchars = 0; fcnt = 0;
                            if (eleft == 0) entry_done();
                            else ph = P_EDATA;
                        end
                    end
                end
                P_VEND: begin
                    if (blen > 0) blen--;
                    if (fcnt > 0) fcnt--;
                    if (fcnt == 0) to_field(P_COUNT);
                end
                P_EDATA: begin
                    if (blen > 0) blen--;
                    value_byte(b);
                end
                default: ;
            endcase
            if (fpos != 32'hFFFFFFFF) fpos++;
        endfunction

        function void check_result(logic [fmp_pkg::OUT_DW-1:0] d, logic [1:0] k, logic l);
            t_meta_result e;
            bit bad;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d tdata=%h last=%0d", k, d, l);
                return;
            end
            e = pending_q.pop_front();
            bad = (k !== e.kind) || (d[1:0] !== e.tag) || (d[9:2] !== e.vbyte) ||
                  (l !== e.vlast) || (d[29:10] !== e.rate) || (d[65:30] !== e.samples) ||
                  (d[97:66] !== e.dur) || (d[129:98] !== e.track) ||
                  (d[131:130] !== e.err) || (d[135:132] !== 4'd0);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp kind=%0d tag=%0d byte=%h last=%0d rate=%0d ",
                              "smp=%0d dur=%0d trk=%0d err=%0d | got kind=%0d tag=%0d ",
                              "byte=%h last=%0d rate=%0d smp=%0d dur=%0d trk=%0d err=%0d"},
                             e.kind, e.tag, e.vbyte, e.vlast, e.rate, e.samples, e.dur,
                             e.track, e.err, k, d[1:0], d[9:2], l, d[29:10], d[65:30],
                             d[97:66], d[129:98], d[131:130]);
            end
        endfunction
    endclass

    logic              i_clk, i_rst_n;
    logic              i_s_axis_tvalid, o_s_axis_tready;
    logic [7:0]        i_s_axis_tdata;   // data_byte[7:0]
    logic              i_s_axis_tuser;   // file_start
    logic              o_m_axis_tvalid, i_m_axis_tready;
    logic [fmp_pkg::OUT_DW-1:0] o_m_axis_tdata; // tag, value, rate, samples, duration, track, error
    logic [1:0]        o_m_axis_tuser;   // kind[1:0]
    logic              o_m_axis_tlast;   // value_last

    flac_metadata_parser dut (.*);

    flac_scoreboard sb = new();
    int  sent_items;
    bit  tx_busy_mode, rx_busy_mode;
    bit  drained_once;
    int  rx_stall;
    byte unsigned fbytes[$];

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // check before noting: a result never comes out at the edge its item goes in
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_byte(i_s_axis_tdata, i_s_axis_tuser);
        end
    end

    always @(negedge i_clk) begin
        if (!rx_busy_mode) i_m_axis_tready <= 1'b1;
        else if (rx_stall > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if ($urandom_range(0, 99) < 65) i_m_axis_tready <= 1'b1;
        else begin
            i_m_axis_tready <= 1'b0;
            rx_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
    end

    // called at a falling edge; returns at a falling edge after the item is taken
    task automatic send_byte(logic [7:0] b, logic fs);
        int gap, r;
        r = $urandom_range(0, 99);
        gap = (!tx_busy_mode || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                       : $urandom_range(8, 30);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_file(bit mark_start);
        foreach (fbytes[i]) send_byte(fbytes[i], mark_start && i == 0);
        fbytes.delete();
        tx_busy_mode = $urandom_range(0, 3) != 0;
        rx_busy_mode = $urandom_range(0, 3) != 0;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic void put_magic();
        fbytes.push_back("f"); fbytes.push_back("L");
        fbytes.push_back("a"); fbytes.push_back("C");
    endfunction

    function automatic void put_header(bit last, int typ, int unsigned len);
        fbytes.push_back({last, typ[6:0]});
        fbytes.push_back(len[23:16]); fbytes.push_back(len[15:8]); fbytes.push_back(len[7:0]);
    endfunction

    function automatic void put_le32(int unsigned v);
        for (int i = 0; i < 4; i++) fbytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_stream_info(bit last);
        int unsigned rt;
        put_header(last, 0, 34);
        rt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20'hFFFFF);
        for (int i = 0; i < 34; i++) begin
            if (i == 10) fbytes.push_back(rt[19:12]);
            else if (i == 11) fbytes.push_back(rt[11:4]);
            else if (i == 12) fbytes.push_back({rt[3:0], 4'($urandom)});
            else fbytes.push_back($urandom_range(0, 255));
        end
    endfunction

    // one comment entry body: key in random case, then value
    function automatic void make_entry(ref byte unsigned ent[$], input int maxval);
        string names[7] = '{"TRACKNUMBER=", "ARTIST=", "ALBUM=", "TITLE=", "DATE=",
                            "GENRE=", "ARTISTS="};
        string k;
        int n;
        k = names[$urandom_range(0, 6)];
        for (int i = 0; i < k.len(); i++)
            ent.push_back(($urandom_range(0, 1) && k[i] >= "A" && k[i] <= "Z") ?
                          k[i] + 32 : k[i]);
        n = $urandom_range(0, maxval);
        for (int i = 0; i < n; i++) begin
            if (k == "TRACKNUMBER=" && $urandom_range(0, 5) != 0)
                ent.push_back("0" + $urandom_range(0, 9));
            else ent.push_back($urandom_range(0, 255));
        end
    endfunction

    function automatic void put_comments(bit last, int nent, int maxval, int slack);
        byte unsigned body[$], ent[$];
        int vend;
        vend = $urandom_range(0, 8);
        put_le32(0);
        body = fbytes;
        fbytes.delete();
        put_le32(vend);
        repeat (vend) fbytes.push_back($urandom_range(0, 255));
        put_le32(nent);
        repeat (nent) begin
            ent.delete();
            make_entry(ent, maxval);
            put_le32(ent.size());
            foreach (ent[i]) fbytes.push_back(ent[i]);
        end
        repeat (slack) fbytes.push_back($urandom_range(0, 255));
        ent = fbytes;
        fbytes = body;
        void'(fbytes.pop_back()); void'(fbytes.pop_back());
        void'(fbytes.pop_back()); void'(fbytes.pop_back());
        put_header(last, 4, ent.size());
        foreach (ent[i]) fbytes.push_back(ent[i]);
    endfunction

    function automatic void build_random_file();
        int r, pos;
        put_magic();
        if ($urandom_range(0, 4) != 0) put_stream_info(0);
        if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 12);
            put_header(0, $urandom_range(1, 127), r);
            repeat (r) fbytes.push_back($urandom_range(0, 255));
        end
        put_comments($urandom_range(0, 1), $urandom_range(0, 4), 12, $urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 8) begin
            pos = $urandom_range(0, fbytes.size() - 1);
            fbytes[pos] = $urandom_range(0, 255);
        end else if (r < 14) begin
            repeat ($urandom_range(1, 10)) void'(fbytes.pop_back());
        end else if (r < 18) begin
            fbytes.delete();
            repeat ($urandom_range(1, 6)) fbytes.push_back($urandom_range(0, 255));
        end
        // trailing bytes; the parser ignores any that come after the file has ended
        repeat ($urandom_range(0, 2)) fbytes.push_back($urandom_range(0, 255));
    endfunction

    initial begin
        byte unsigned ent[$];
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_m_axis_tready = 1'b0;
        tx_busy_mode = 1'b0;
        rx_busy_mode = 1'b0;
        drained_once = 1'b0;
        rx_stall = 0;
        sent_items = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // no file start flag after reset; stream info flagged last
        put_magic(); put_stream_info(1); send_file(0);
        // bad magic, then skipped last block finishes at its header
        fbytes = '{"f", "L", "x"}; send_file(1);
        put_magic(); put_header(1, 1, 5); send_file(1);
        // skip past the window, oversize comment block skipped, empty block
        put_magic(); put_header(0, 127, 24'hFFFFFF); send_file(1);
        put_magic(); put_header(0, 3, 0); put_header(1, 4, 600); send_file(1);
        // comment block too short, vendor overrun, zero entries
        put_magic(); put_header(0, 4, 2); send_file(1);
        put_magic(); put_header(0, 4, 8); put_le32(200); send_file(1);
        put_magic(); put_header(0, 4, 8); put_le32(0); put_le32(0); send_file(1);
        // entry overrun, then a long value hitting the character cap
        put_magic(); put_header(0, 4, 12); put_le32(0); put_le32(1); put_le32(99);
        send_file(1);
        put_magic(); put_stream_info(0); put_header(1, 4, 90);
        put_le32(0); put_le32(2); put_le32(74);
        ent = '{"t", "I", "T", "l", "E", "="};
        foreach (ent[i]) fbytes.push_back(ent[i]);
        for (int i = 0; i < 68; i++) fbytes.push_back(i == 3 ? 8'h00 : 8'hFF - i);
        put_le32(0);
        send_file(1);
        put_magic(); put_comments(0, 3, 14, 2); send_file(1);

        while (sent_items < 700) begin
            build_random_file();
            send_file(1);
            if (!drained_once && sent_items > 350) begin
                wait_drained();
                drained_once = 1'b1;
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/fmp_pkg.sv
rtl/fmp_div.sv
rtl/fmp_dpath.sv
rtl/fmp_ctrl.sv
rtl/flac_metadata_parser.sv
test/flac_metadata_parser_tb.sv
